// ===== hdl/clrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle stack package
// Shared types, codes and sizing constants for the clip rectangle stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clrs_pkg;

    // Number of stack levels and the widths that follow from it.
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    // Field widths of the command and result transfers.
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int OSIZE_W = 16;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored level: the running intersection of all rectangles up to it.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] bottom;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  top;
    } t_level;

    // Stack state after the command currently being applied.
    typedef struct packed {
        logic    enable;
        t_level  level;
        t_status status;
    } t_stack_next;

endpackage : clrs_pkg

`default_nettype wire

// ===== hdl/clrs_isect.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle intersection
// Turns a pushed rectangle into edges and intersects it with the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clrs_isect
    import clrs_pkg::*;
(
    input  wire logic                      i_has_top,
    input  wire t_level                    i_top,
    input  wire logic signed [COORD_W-1:0] i_rect_x,
    input  wire logic signed [COORD_W-1:0] i_rect_y,
    input  wire logic [SIZE_W-1:0]         i_rect_width,
    input  wire logic [SIZE_W-1:0]         i_rect_height,
    output t_level                         o_level
);

    t_level rect;

    // The pushed rectangle as left, bottom, right and top edges.
    always_comb begin
        rect.left   = i_rect_x;
        rect.bottom = i_rect_y;
        rect.right  = $signed({i_rect_x[COORD_W-1], i_rect_x})
                    + $signed({{(EDGE_W-SIZE_W){1'b0}}, i_rect_width});
        rect.top    = $signed({i_rect_y[COORD_W-1], i_rect_y})
                    + $signed({{(EDGE_W-SIZE_W){1'b0}}, i_rect_height});
    end

    // Intersect with the level below when there is one.
    always_comb begin
        o_level = rect;
        if (i_has_top) begin
            if (i_top.left > rect.left) begin
                o_level.left = i_top.left;
            end
            if (i_top.bottom > rect.bottom) begin
                o_level.bottom = i_top.bottom;
            end
            if (i_top.right < rect.right) begin
                o_level.right = i_top.right;
            end
            if (i_top.top < rect.top) begin
                o_level.top = i_top.top;
            end
        end
    end

endmodule : clrs_isect

`default_nettype wire

// ===== hdl/clrs_stack.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle level store
// Holds the stacked levels, the level count and a copy of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clrs_stack
    import clrs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   i_command,
    input  wire t_level i_push_level,
    output logic        o_has_top,
    output t_level      o_top,
    output t_stack_next o_next
);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_level             r_top;
    t_level             n_top;
    t_level             r_levels [STACK_DEPTH];
    logic               full;
    logic               do_push;
    logic [IDX_W-1:0]   push_idx;
    logic [IDX_W-1:0]   below_idx;
    logic [COUNT_W-1:0] below_count;

    assign full        = (r_count == COUNT_W'(STACK_DEPTH));
    assign push_idx    = r_count[IDX_W-1:0];
    assign below_count = (r_count > COUNT_W'(1)) ? (r_count - COUNT_W'(2)) : '0;
    assign below_idx   = below_count[IDX_W-1:0];
    assign o_has_top   = (r_count != '0);
    assign o_top       = r_top;

    // Next count, next top level and status for the command in hand.
    always_comb begin
        n_count        = r_count;
        n_top          = r_top;
        do_push        = 1'b0;
        o_next.status  = ST_OK;
        if (i_command == CMD_PUSH) begin
            if (full) begin
                o_next.status = ST_FULL;
            end else begin
                do_push = 1'b1;
                n_count = r_count + COUNT_W'(1);
                n_top   = i_push_level;
            end
        end else begin
            if (r_count == '0) begin
                o_next.status = ST_EMPTY;
            end else begin
                n_count = r_count - COUNT_W'(1);
                n_top   = r_levels[below_idx];
            end
        end
        o_next.enable = (n_count != '0);
        o_next.level  = n_top;
    end

    // Level count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_valid) begin
            r_count <= n_count;
        end
    end

    // Top level copy and the level array; both are read only below the count.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_top <= n_top;
        end
        if (i_valid && do_push) begin
            r_levels[push_idx] <= i_push_level;
        end
    end

endmodule : clrs_stack

`default_nettype wire

// ===== hdl/clip_rect_stack.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle stack
// Push and pop clip rectangles and report the effective scissor rectangle.
// ----------------------------------------------------------------------------
// A command accepted by the input register gives its result strobe from the
// result register that follows it.
// Throughput: one command every cycle; busy is never raised, since each
// command touches only the levels at the top of the stack and the receiver cannot stall.
// Reset empties the stack; stored levels are not cleared and are only read
// below the level count.
`timescale 1ns / 1ps
`default_nettype none

module clip_rect_stack
    import clrs_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_command,
    input  wire logic signed [COORD_W-1:0] i_rect_x,
    input  wire logic signed [COORD_W-1:0] i_rect_y,
    input  wire logic [SIZE_W-1:0]         i_rect_width,
    input  wire logic [SIZE_W-1:0]         i_rect_height,
    output logic                           o_valid,
    output logic                           o_clip_enable,
    output logic signed [COORD_W-1:0]      o_clip_x,
    output logic signed [COORD_W-1:0]      o_clip_y,
    output logic [OSIZE_W-1:0]             o_clip_width,
    output logic [OSIZE_W-1:0]             o_clip_height,
    output logic [1:0]                     o_status
);

    logic                      r_in_valid;
    logic                      r_command;
    logic signed [COORD_W-1:0] r_rect_x;
    logic signed [COORD_W-1:0] r_rect_y;
    logic [SIZE_W-1:0]         r_rect_width;
    logic [SIZE_W-1:0]         r_rect_height;

    logic                      r_out_valid;
    logic                      r_clip_enable;
    logic signed [COORD_W-1:0] r_clip_x;
    logic signed [COORD_W-1:0] r_clip_y;
    logic [OSIZE_W-1:0]        r_clip_width;
    logic [OSIZE_W-1:0]        r_clip_height;
    logic [1:0]                r_status;

    logic [OSIZE_W-1:0]        n_clip_width;
    logic [OSIZE_W-1:0]        n_clip_height;
    logic signed [EDGE_W:0]    w_diff;
    logic signed [EDGE_W:0]    h_diff;

    logic                      has_top;
    t_level                    top_level;
    t_level                    push_level;
    t_stack_next               stack_next;

    assign busy = 1'b0;

    // Input register: one command transfer per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_command     <= i_command;
            r_rect_x      <= i_rect_x;
            r_rect_y      <= i_rect_y;
            r_rect_width  <= i_rect_width;
            r_rect_height <= i_rect_height;
        end
    end

    // Intersection of the pushed rectangle with the current top level.
    clrs_isect u_isect (
        .i_has_top     (has_top),
        .i_top         (top_level),
        .i_rect_x      (r_rect_x),
        .i_rect_y      (r_rect_y),
        .i_rect_width  (r_rect_width),
        .i_rect_height (r_rect_height),
        .o_level       (push_level)
    );

    // Level store and count.
    clrs_stack u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_command    (r_command),
        .i_push_level (push_level),
        .o_has_top    (has_top),
        .o_top        (top_level),
        .o_next       (stack_next)
    );

    // Size of the new top level, clamped to zero when it is empty.
    always_comb begin
        w_diff = $signed({stack_next.level.right[EDGE_W-1], stack_next.level.right})
               - $signed({{2{stack_next.level.left[COORD_W-1]}}, stack_next.level.left});
        h_diff = $signed({stack_next.level.top[EDGE_W-1], stack_next.level.top})
               - $signed({{2{stack_next.level.bottom[COORD_W-1]}}, stack_next.level.bottom});
        n_clip_width  = (w_diff > 0) ? w_diff[OSIZE_W-1:0] : '0;
        n_clip_height = (h_diff > 0) ? h_diff[OSIZE_W-1:0] : '0;
    end

    // Result register: the strobe marks each result transfer for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_clip_enable <= stack_next.enable;
            r_status      <= stack_next.status;
            if (stack_next.enable) begin
                r_clip_x      <= stack_next.level.left;
                r_clip_y      <= stack_next.level.bottom;
                r_clip_width  <= n_clip_width;
                r_clip_height <= n_clip_height;
            end else begin
                r_clip_x      <= '0;
                r_clip_y      <= '0;
                r_clip_width  <= '0;
                r_clip_height <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_clip_enable = r_clip_enable;
    assign o_clip_x      = r_clip_x;
    assign o_clip_y      = r_clip_y;
    assign o_clip_width  = r_clip_width;
    assign o_clip_height = r_clip_height;
    assign o_status      = r_status;

endmodule : clip_rect_stack

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Clip rectangle stack testbench
// Drives push and pop commands into the clip rectangle stack and checks every
// result strobe against a local model of the scissor stack. Directed tests
// cover the empty and full stack, extreme edges and disjoint rectangles.
// Random tests then run nested push and pop sequences, with and without gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import clrs_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 12;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 1000;

    // Expected contents of one result transfer.
    typedef struct {
        logic                      enable;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [OSIZE_W-1:0]        width;
        logic [OSIZE_W-1:0]        height;
        t_status                   status;
    } t_scissor;

    // Styles of random rectangle content.
    typedef enum int {
        RECT_NESTED,
        RECT_ANY,
        RECT_EXTREME
    } t_rect_style;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      i_command = CMD_PUSH;
    logic signed [COORD_W-1:0] i_rect_x = '0;
    logic signed [COORD_W-1:0] i_rect_y = '0;
    logic [SIZE_W-1:0]         i_rect_width = '0;
    logic [SIZE_W-1:0]         i_rect_height = '0;
    logic                      busy;
    logic                      o_valid;
    logic                      o_clip_enable;
    logic signed [COORD_W-1:0] o_clip_x;
    logic signed [COORD_W-1:0] o_clip_y;
    logic [OSIZE_W-1:0]        o_clip_width;
    logic [OSIZE_W-1:0]        o_clip_height;
    logic [1:0]                o_status;

    // Model state of the scissor stack.
    t_level   clip_levels [STACK_DEPTH];
    int       level_count = 0;
    t_scissor scissor_queue [$];

    int error_count = 0;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;

    clip_rect_stack i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_valid       (o_valid),
        .o_clip_enable (o_clip_enable),
        .o_clip_x      (o_clip_x),
        .o_clip_y      (o_clip_y),
        .o_clip_width  (o_clip_width),
        .o_clip_height (o_clip_height),
        .o_status      (o_status)
    );

    // Clock generation.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: give up if the run goes far beyond its expected length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one command to the model and return the scissor it leaves.
    function automatic t_scissor apply_clip_command(
        input logic                      cmd,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [SIZE_W-1:0]         w,
        input logic [SIZE_W-1:0]         h
    );
        t_scissor res;
        t_level   below;
        t_level   top_level;
        int       left;
        int       bottom;
        int       right;
        int       top;

        res.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (level_count >= STACK_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                left   = int'(x);
                bottom = int'(y);
                right  = int'(x) + int'({1'b0, w});
                top    = int'(y) + int'({1'b0, h});
                // Intersect with the running scissor of the level below.
                if (level_count > 0) begin
                    below = clip_levels[level_count - 1];
                    if (int'($signed(below.left)) > left) left = int'($signed(below.left));
                    if (int'($signed(below.bottom)) > bottom) bottom = int'($signed(below.bottom));
                    if (int'($signed(below.right)) < right) right = int'($signed(below.right));
                    if (int'($signed(below.top)) < top) top = int'($signed(below.top));
                end
                top_level.left   = left[COORD_W-1:0];
                top_level.bottom = bottom[COORD_W-1:0];
                top_level.right  = right[EDGE_W-1:0];
                top_level.top    = top[EDGE_W-1:0];
                clip_levels[level_count] = top_level;
                level_count++;
            end
        end else begin
            if (level_count == 0) res.status = ST_EMPTY;
            else level_count--;
        end

        // Report the scissor of the top level, or all zero when empty.
        res.enable = 1'b0;
        res.x      = '0;
        res.y      = '0;
        res.width  = '0;
        res.height = '0;
        if (level_count > 0) begin
            top_level  = clip_levels[level_count - 1];
            left       = int'($signed(top_level.left));
            bottom     = int'($signed(top_level.bottom));
            right      = int'($signed(top_level.right));
            top        = int'($signed(top_level.top));
            res.enable = 1'b1;
            res.x      = top_level.left;
            res.y      = top_level.bottom;
            if (right > left) res.width = OSIZE_W'(right - left);
            if (top > bottom) res.height = OSIZE_W'(top - bottom);
        end
        return res;
    endfunction

    // Record the expected scissor for every accepted command transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            scissor_queue.insert(scissor_queue.size(),
                                 apply_clip_command(i_command, i_rect_x, i_rect_y,
                                                    i_rect_width, i_rect_height));
        end
    end

    // Compare each result transfer with the oldest expected scissor.
    always @(posedge i_clk) begin
        t_scissor want;
        if (i_rst_n && o_valid) begin
            if (scissor_queue.size() == 0) begin
                $error("result transfer with no command outstanding");
                error_count++;
            end else begin
                want = scissor_queue.pop_front();
                if (o_clip_enable !== want.enable) begin
                    $error("clip_enable: expected %0d, got %0d", want.enable, o_clip_enable);
                    error_count++;
                end
                if (o_clip_x !== want.x) begin
                    $error("clip_x: expected %0d, got %0d", want.x, o_clip_x);
                    error_count++;
                end
                if (o_clip_y !== want.y) begin
                    $error("clip_y: expected %0d, got %0d", want.y, o_clip_y);
                    error_count++;
                end
                if (o_clip_width !== want.width) begin
                    $error("clip_width: expected %0d, got %0d", want.width, o_clip_width);
                    error_count++;
                end
                if (o_clip_height !== want.height) begin
                    $error("clip_height: expected %0d, got %0d", want.height, o_clip_height);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Present one command, hold it until it is accepted, then maybe pause.
    task automatic send_command(
        input logic                      cmd,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [SIZE_W-1:0]         w,
        input logic [SIZE_W-1:0]         h
    );
        start         <= 1'b1;
        i_command     <= cmd;
        i_rect_x      <= x;
        i_rect_y      <= y;
        i_rect_width  <= w;
        i_rect_height <= h;
        do @(posedge i_clk); while (busy);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input t_rect_style style);
        case (style)
            RECT_NESTED: return COORD_W'($urandom_range(0, 600)) - COORD_W'(300);
            RECT_ANY:    return COORD_W'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input t_rect_style style);
        case (style)
            RECT_NESTED: return SIZE_W'($urandom_range(0, 700));
            RECT_ANY:    return SIZE_W'($urandom());
            default: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return SIZE_W'(1);
                endcase
            end
        endcase
    endfunction

    // Send a command with rectangle fields of a randomly chosen style.
    task automatic send_random(input logic cmd);
        t_rect_style style;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) style = RECT_NESTED;
        else if (pick < 88) style = RECT_ANY;
        else style = RECT_EXTREME;
        send_command(cmd, pick_coord(style), pick_coord(style),
                     pick_size(style), pick_size(style));
    endtask

    // Empty stack: pops are refused, and a single push reports its own rectangle.
    task automatic test_empty_stack();
        send_command(CMD_POP, 16'sh1234, -16'sd5, 15'h7fff, 15'h0);
        send_command(CMD_PUSH, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff);
        send_command(CMD_POP, '0, '0, '0, '0);
        send_command(CMD_POP, 16'sh8000, 16'sh8000, 15'h0, 15'h7fff);
    endtask

    // Fill the stack through extreme, nested, partial and disjoint rectangles.
    task automatic test_full_stack();
        send_command(CMD_PUSH, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff);
        send_command(CMD_PUSH, -16'sd100, -16'sd50, 15'd300, 15'd200);
        send_command(CMD_PUSH, -16'sd200, 16'sd0, 15'd150, 15'd100);
        send_command(CMD_PUSH, 16'sd0, 16'sd0, 15'd0, 15'd0);
        send_command(CMD_PUSH, 16'sd10, 16'sd10, 15'd5, 15'd5);
        repeat (STACK_DEPTH - 5) begin
            send_command(CMD_PUSH, pick_coord(RECT_EXTREME), pick_coord(RECT_EXTREME),
                         pick_size(RECT_EXTREME), pick_size(RECT_EXTREME));
        end
        // Stack is now full: this push is refused and the scissor is unchanged.
        send_command(CMD_PUSH, 16'sd1, 16'sd1, 15'd1, 15'd1);
        send_command(CMD_POP, '0, '0, '0, '0);
    endtask

    // Random walk over the stack depth, mostly well formed with some noise.
    task automatic test_random_nesting(input int count, input int start_depth);
        int  depth;
        bit  push;
        depth = start_depth;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) push = ($urandom_range(0, 1) == 0);
            else if (depth == 0) push = ($urandom_range(0, 9) < 9);
            else push = ($urandom_range(0, 99) < 55);
            send_random(push ? CMD_PUSH : CMD_POP);
            if (push && depth < STACK_DEPTH) depth++;
            else if (!push && depth > 0) depth--;
        end
    endtask

    // Fill the stack past full, then drain it past empty, several times over.
    task automatic test_fill_drain(input int rounds, input int start_depth);
        int extra;
        for (int r = 0; r < rounds; r++) begin
            gaps_on = (r % 3 != 2);
            extra   = $urandom_range(1, 3);
            repeat (STACK_DEPTH + extra - ((r == 0) ? start_depth : 0)) send_random(CMD_PUSH);
            repeat (STACK_DEPTH + extra) send_random(CMD_POP);
        end
    endtask

    // Back to back commands with no gaps at all to close the run.
    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_random(($urandom_range(0, 99) < 52) ? CMD_PUSH : CMD_POP);
        end
        start <= 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_full_stack();
        test_random_nesting(1300, STACK_DEPTH - 1);
        test_fill_drain(8, 0);
        test_back_to_back(240);

        // Let the outstanding results arrive, then allow for the pipeline.
        for (int n = 0; n < DRAIN_LIMIT && scissor_queue.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (scissor_queue.size() != 0) begin
            $error("%0d expected results never arrived", scissor_queue.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
